// File: src/mmcd_pkg.sv
// Shared widths, register indexes and row conversion for the min/max column decimator.
`timescale 1ns / 1ps
package mmcd_pkg;

  // Field widths of the item and configuration interfaces
  localparam int SAMPLE_W   = 8;
  localparam int COORD_W    = 10;
  localparam int SCOUNT_W   = 16;
  localparam int CCOUNT_W   = 9;
  localparam int SCALE_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int SCALE_FRAC = 16;

  // Register reset values
  localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST = 16'd8192;
  localparam logic [CCOUNT_W-1:0] COLUMN_COUNT_RST = 9'd278;
  localparam logic [SCALE_W-1:0]  Y_SCALE_RST      = 24'd65536;
  localparam logic [COORD_W-1:0]  BASELINE_Y_RST   = 10'd200;
  localparam logic [COORD_W-1:0]  X_ORIGIN_RST     = 10'd0;

  // Running extremes at the start of an interval
  localparam logic [SAMPLE_W-1:0] MIN_INIT = 8'd255;
  localparam logic [SAMPLE_W-1:0] MAX_INIT = 8'd0;

  // Largest screen coordinate
  localparam logic [COORD_W-1:0] COORD_MAX = 10'd1023;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SAMPLE_COUNT = 3'd0,
    CFG_COLUMN_COUNT = 3'd1,
    CFG_Y_SCALE      = 3'd2,
    CFG_BASELINE_Y   = 3'd3,
    CFG_X_ORIGIN     = 3'd4
  } cfg_idx_t;

  // Screen row of a sample code: baseline - round(v * scale), clamped at zero
  function automatic logic [COORD_W-1:0] to_row(
    input logic [SAMPLE_W-1:0] v,
    input logic [SCALE_W-1:0]  scale,
    input logic [COORD_W-1:0]  base
  );
    logic [SAMPLE_W+SCALE_W-1:0] prod;
    logic [SAMPLE_W+SCALE_W:0]   rnd;
    logic [SAMPLE_W+SCALE_W-SCALE_FRAC:0] drop;
    logic [SAMPLE_W+SCALE_W-SCALE_FRAC:0] base_ext;
    logic [SAMPLE_W+SCALE_W-SCALE_FRAC:0] diff;
    prod     = (SAMPLE_W+SCALE_W)'(v) * (SAMPLE_W+SCALE_W)'(scale);
    rnd      = {1'b0, prod} + (SAMPLE_W+SCALE_W+1)'(1 << (SCALE_FRAC - 1));
    drop     = rnd[SAMPLE_W+SCALE_W:SCALE_FRAC];
    base_ext = (SAMPLE_W+SCALE_W-SCALE_FRAC+1)'(base);
    diff     = base_ext - drop;
    to_row   = (drop >= base_ext) ? '0 : diff[COORD_W-1:0];
  endfunction

endpackage

// File: src/min_max_column_decimator.sv
// Min/max column decimator: per-interval extremes of a sample frame, emitted as screen lines.
// Pipeline: input register at the edge that accepts an item, then interval state stage, then
//   row conversion into the output register; out_tready back-pressure can stall all of them.
// One item per cycle when unstalled; the interval compare uses one multiplier at the input register.
// Items that close no interval give no result; the last interval of a frame is never emitted.
// Reset (rst_n low, synchronous): registers to their defaults, frame state to its start,
//   pipeline emptied.
`timescale 1ns / 1ps
module min_max_column_decimator
  import mmcd_pkg::*;
#(
  parameter int MAX_SAMPLES = 32768,
  parameter int MAX_COLUMNS = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Sample stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] sample
  // Column stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [9:0] column_x, [19:10] row_of_min, [29:20] row_of_max
  output logic                  out_tlast   // final_column
);

  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int LEN_W  = $clog2(MAX_SAMPLES + 1);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int N_W    = $clog2(MAX_COLUMNS + 1);
  localparam int ACC_W  = IDX_W + COL_W + 2;
  localparam int LCMP_W = (LEN_W > SCOUNT_W) ? LEN_W : SCOUNT_W;
  localparam int CCMP_W = (COL_W > CCOUNT_W) ? COL_W : CCOUNT_W;
  localparam int CX_W   = ((COL_W > COORD_W) ? COL_W : COORD_W) + 1;

  // Configuration registers
  logic [SCOUNT_W-1:0] sample_count_r;
  logic [CCOUNT_W-1:0] column_count_r;
  logic [SCALE_W-1:0]  y_scale_r;
  logic [COORD_W-1:0]  baseline_y_r;
  logic [COORD_W-1:0]  x_origin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
      y_scale_r      <= Y_SCALE_RST;
      baseline_y_r   <= BASELINE_Y_RST;
      x_origin_r     <= X_ORIGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[SCOUNT_W-1:0];
        CFG_COLUMN_COUNT: column_count_r <= cfg_wdata[CCOUNT_W-1:0];
        CFG_Y_SCALE:      y_scale_r      <= cfg_wdata[SCALE_W-1:0];
        CFG_BASELINE_Y:   baseline_y_r   <= cfg_wdata[COORD_W-1:0];
        CFG_X_ORIGIN:     x_origin_r     <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length and column count, saturated to the build limits
  logic [LCMP_W-1:0] len_wide;
  logic [LEN_W-1:0]  len;
  logic [CCMP_W-1:0] cols_wide;
  logic [COL_W-1:0]  cols;
  logic [N_W-1:0]    n_int;

  always_comb begin
    len_wide = (LCMP_W'(sample_count_r) > LCMP_W'(MAX_SAMPLES)) ?
               LCMP_W'(MAX_SAMPLES) : LCMP_W'(sample_count_r);
    if (len_wide == '0) begin
      len_wide = LCMP_W'(1);
    end
    len       = len_wide[LEN_W-1:0];
    cols_wide = (CCMP_W'(column_count_r) > CCMP_W'(MAX_COLUMNS - 1)) ?
                CCMP_W'(MAX_COLUMNS - 1) : CCMP_W'(column_count_r);
    cols      = cols_wide[COL_W-1:0];
    n_int     = N_W'(cols) + N_W'(1);
  end

  // Pipeline handshakes
  logic a_valid_r, b_valid_r, out_valid_r;
  logic c_ready, b_ready, a_fire, b_take, in_fire;

  assign c_ready   = !out_valid_r || out_tready;
  assign b_ready   = !b_valid_r || c_ready;
  assign a_fire    = a_valid_r && b_ready;
  assign b_take    = b_valid_r && c_ready;
  assign in_tready = !a_valid_r || b_ready;
  assign in_fire   = in_tvalid && in_tready;

  // Input stage: latch sample, sample index product and frame-end flag
  logic [IDX_W-1:0]    s_r, s_nxt;
  logic [SAMPLE_W-1:0] a_sample_r;
  logic [ACC_W-1:0]    a_prod_r;
  logic                a_last_r;
  logic                s_last;

  assign s_last = (LEN_W'(s_r) + LEN_W'(1)) >= len;
  assign s_nxt  = s_last ? '0 : s_r + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r       <= '0;
      a_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s_r <= s_nxt;
      end
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_sample_r <= in_tdata[SAMPLE_W-1:0];
      a_prod_r   <= ACC_W'(n_int) * ACC_W'(IDX_W'(s_r) + (IDX_W+1)'(2));
      a_last_r   <= s_last;
    end
  end

  // Interval stage: running extremes, boundary accumulator, column counter
  logic [SAMPLE_W-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                loaded_r, loaded_nxt;
  logic [ACC_W-1:0]    acc_use, two_len;
  logic [SAMPLE_W-1:0] v_min, v_max;
  logic                emit;

  logic [SAMPLE_W-1:0] b_min_r, b_max_r;
  logic [COL_W-1:0]    b_col_r;
  logic                b_final_r;

  always_comb begin
    two_len = ACC_W'({len, 1'b0});
    acc_use = loaded_r ? acc_r : two_len + ACC_W'(n_int);
    v_min   = (a_sample_r < min_r) ? a_sample_r : min_r;
    v_max   = (a_sample_r > max_r) ? a_sample_r : max_r;
    emit    = (col_r < cols) && ({a_prod_r[ACC_W-2:0], 1'b0} > acc_use);

    min_nxt    = min_r;
    max_nxt    = max_r;
    col_nxt    = col_r;
    acc_nxt    = acc_r;
    loaded_nxt = loaded_r;
    if (a_fire) begin
      loaded_nxt = 1'b1;
      if (emit) begin
        min_nxt = MIN_INIT;
        max_nxt = MAX_INIT;
        col_nxt = col_r + COL_W'(1);
        acc_nxt = acc_use + two_len;
      end else begin
        min_nxt = v_min;
        max_nxt = v_max;
        acc_nxt = acc_use;
      end
      // Return to frame start after the last sample
      if (a_last_r) begin
        min_nxt    = MIN_INIT;
        max_nxt    = MAX_INIT;
        col_nxt    = '0;
        acc_nxt    = '0;
        loaded_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= MIN_INIT;
      max_r     <= MAX_INIT;
      col_r     <= '0;
      acc_r     <= '0;
      loaded_r  <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      col_r    <= col_nxt;
      acc_r    <= acc_nxt;
      loaded_r <= loaded_nxt;
      if (a_fire) begin
        b_valid_r <= emit;
      end else if (b_take) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && emit) begin
      b_min_r   <= v_min;
      b_max_r   <= v_max;
      b_col_r   <= col_r;
      b_final_r <= (CCMP_W'(col_r) + CCMP_W'(1)) == CCMP_W'(cols);
    end
  end

  // Output stage: screen column and rows into the result register
  logic [CX_W-1:0]    cx_sum;
  logic [COORD_W-1:0] col_x_nxt;
  logic [COORD_W-1:0] out_col_x_r, out_row_min_r, out_row_max_r;
  logic               out_final_r;

  assign cx_sum    = CX_W'(x_origin_r) + CX_W'(b_col_r);
  assign col_x_nxt = (cx_sum > CX_W'(COORD_MAX)) ? COORD_MAX : cx_sum[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_ready) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_take) begin
      out_col_x_r   <= col_x_nxt;
      out_row_min_r <= to_row(b_min_r, y_scale_r, baseline_y_r);
      out_row_max_r <= to_row(b_max_r, y_scale_r, baseline_y_r);
      out_final_r   <= b_final_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_row_max_r, out_row_min_r, out_col_x_r};
  assign out_tlast  = out_final_r;

  // Checks on the pipeline control
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !b_ready) |=> a_valid_r)
    else $error("input stage lost an item while stalled");

  ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> in_tready)
    else $error("input not ready with empty input stage");

  frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && a_last_r) |=> (col_r == '0 && !loaded_r && min_r == MIN_INIT))
    else $error("frame state not restarted after last sample");

  b_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(b_valid_r) |-> $past(a_fire))
    else $error("interval stage result without a processed item");

endmodule
